// ----- hdl/pcs_pkg.sv -----
// Shared constants and control types of the PID step unit
package pcs_pkg;

    localparam int GAIN_W           = 24;
    localparam int PERIOD_W         = 24;
    localparam int PERIOD_FRAC_BITS = 20;
    localparam int CAP_BITS         = 60;
    localparam int TERM_W           = 64;
    localparam int CFG_INDEX_W      = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1) << PERIOD_FRAC_BITS;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_LOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_HIGH  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TERM_MODE   = 3'd7;

    // item operations
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_OBSERVE = 1'b1;

    // term_mode bits
    localparam int MODE_P_MEAS_BIT = 0;
    localparam int MODE_D_MEAS_BIT = 1;

    typedef struct packed {
        logic start;
        logic divide;
    } t_su_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_su_stat;

endpackage

// ----- hdl/pcs_in_if.sv -----
// Input item channel of the PID step unit
interface pcs_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [DATA_WIDTH-1:0] measured;
    logic [DATA_WIDTH-1:0] target;
    logic [DATA_WIDTH-1:0] applied_output;

    modport source (
        output valid, operation, measured, target, applied_output,
        input  ready
    );

    modport sink (
        input  valid, operation, measured, target, applied_output,
        output ready
    );
endinterface

// ----- hdl/pcs_out_if.sv -----
// Result item channel of the PID step unit
interface pcs_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] control_output;

    modport source (
        output valid, control_output,
        input  ready
    );

    modport sink (
        input  valid, control_output,
        output ready
    );
endinterface

// ----- hdl/pcs_serial_unit.sv -----
// Bit-serial shift-add multiplier and restoring divider shared by all PID terms
module pcs_serial_unit #(
    parameter int WW   = 66,
    parameter int DIVN = 62
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcs_pkg::t_su_ctrl            i_ctrl,
    input  logic [WW-1:0]                i_a,
    input  logic [pcs_pkg::GAIN_W-1:0]   i_b,
    output pcs_pkg::t_su_stat            o_stat,
    output logic [WW-1:0]                o_result
);
    localparam int GW   = pcs_pkg::GAIN_W;
    localparam int NMAX = (DIVN > GW) ? DIVN : GW;
    localparam int CNTW = $clog2(NMAX + 1);

    logic [WW-1:0]   r_a, n_a, r_acc, n_acc;
    logic [GW-1:0]   r_b, n_b, r_rem, n_rem;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy, r_div, n_div, r_done, n_done;
    logic [GW:0]     c_rem_sh, c_rem_sub;
    logic            c_ge;

    always_comb begin
        c_rem_sh  = {r_rem, r_a[DIVN-1]};
        c_rem_sub = c_rem_sh - {1'b0, r_b};
        c_ge      = (c_rem_sh >= {1'b0, r_b});

        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_div  = r_div;
        n_done = 1'b0;

        if (i_ctrl.start) begin
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
            n_rem  = '0;
            n_div  = i_ctrl.divide;
            n_cnt  = i_ctrl.divide ? CNTW'(DIVN) : CNTW'(GW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // numerator / multiplicand moves up one bit per step
            n_a   = r_a << 1;
            n_cnt = r_cnt - CNTW'(1);
            if (r_div) begin
                n_acc = {r_acc[WW-2:0], c_ge};
                n_rem = c_ge ? c_rem_sub[GW-1:0] : c_rem_sh[GW-1:0];
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_b = r_b >> 1;
            end
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_div  <= n_div;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

`ifndef ASSERT_OFF
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("serial unit done without a finished run");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |=> (r_busy && !r_done))
        else $error("serial unit did not start");

    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("serial unit busy with empty count");
`endif

endmodule

// ----- hdl/pid_control_step_unit.sv -----
// PID step unit: fixed-point PID controller step with serial arithmetic
// A compute item (error = target - measured) gives one drive value on the result channel;
// an observe item gives no result, it reloads the previous values and sets the integral sum
// to the clamped applied output in the cycle it is taken. A compute item runs through one
// shared bit-serial unit: four 24-step multiplies (integral gain, period, proportional gain,
// derivative gain) and one restoring divide by the period of
// DATA_WIDTH + 46 + SUM_FRAC_BITS - GAIN_FRAC_BITS steps, plus the control states between them.
// One item is worked on at a time; the result
// sits in an output register, so a new item is taken while it waits to be read.
module pid_control_step_unit #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 16,
    parameter int SUM_FRAC_BITS  = 16,
    localparam int CFG_W = (DATA_WIDTH > pcs_pkg::GAIN_W) ? DATA_WIDTH : pcs_pkg::GAIN_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    pcs_in_if.sink                            i_item,
    pcs_out_if.source                         o_result
);
    localparam int DW   = DATA_WIDTH;
    localparam int GW   = pcs_pkg::GAIN_W;
    localparam int PW   = pcs_pkg::PERIOD_W;
    localparam int PFB  = pcs_pkg::PERIOD_FRAC_BITS;
    localparam int TW   = pcs_pkg::TERM_W;
    localparam int MAGW = DW + 2;
    localparam int ISW  = DW + SUM_FRAC_BITS;
    localparam int IS   = GAIN_FRAC_BITS + PFB - SUM_FRAC_BITS;
    localparam int PSL  = (SUM_FRAC_BITS > GAIN_FRAC_BITS) ? SUM_FRAC_BITS - GAIN_FRAC_BITS : 0;
    localparam int PSR  = (GAIN_FRAC_BITS > SUM_FRAC_BITS) ? GAIN_FRAC_BITS - SUM_FRAC_BITS : 0;
    localparam int DS   = PFB + SUM_FRAC_BITS - GAIN_FRAC_BITS;
    localparam int LW_INT = MAGW + GW + PW;
    localparam int LW_P   = MAGW + GW + PSL;
    localparam int LW_D   = MAGW + GW + DS;
    localparam int WA     = (LW_INT > LW_P) ? LW_INT : LW_P;
    localparam int WB     = (WA > LW_D) ? WA : LW_D;
    localparam int WW     = (WB > pcs_pkg::CAP_BITS + 2) ? WB : pcs_pkg::CAP_BITS + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_I_MUL1  = 4'd1;
    localparam logic [3:0] S_I_MUL2  = 4'd2;
    localparam logic [3:0] S_I_ADD   = 4'd3;
    localparam logic [3:0] S_P_MUL   = 4'd4;
    localparam logic [3:0] S_P_ADD   = 4'd5;
    localparam logic [3:0] S_I_CLAMP = 4'd6;
    localparam logic [3:0] S_RES_P   = 4'd7;
    localparam logic [3:0] S_D_MUL   = 4'd8;
    localparam logic [3:0] S_D_DIV   = 4'd9;
    localparam logic [3:0] S_D_ADD   = 4'd10;
    localparam logic [3:0] S_O_CLAMP = 4'd11;
    localparam logic [3:0] S_ROUND   = 4'd12;

    // configuration
    logic [GW-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [PW-1:0] r_period;
    logic [DW-1:0] r_limit_low, r_limit_high;
    logic          r_reverse;
    logic [1:0]    r_term_mode;

    // loop state and per-item registers
    logic [3:0]     r_state, n_state;
    logic           r_started, n_started;
    logic [DW-1:0]  r_prev_meas, n_prev_meas;
    logic [DW:0]    r_prev_err, n_prev_err;
    logic [ISW-1:0] r_isum, n_isum;
    logic [DW:0]    r_err, n_err, r_xp, n_xp;
    logic [DW+1:0]  r_xd, n_xd;
    logic [TW-1:0]  r_sum, n_sum, r_pt, n_pt;
    logic           r_out_valid, n_out_valid;
    logic [DW-1:0]  r_out_data, n_out_data;

    pcs_pkg::t_su_ctrl su_ctrl;
    pcs_pkg::t_su_stat su_stat;
    logic [WW-1:0]     su_a, su_res;
    logic [GW-1:0]     su_b;

    logic           c_accept, c_p_meas, c_d_meas;
    logic [DW-1:0]  c_pm, c_app_cl;
    logic [DW:0]    c_err, c_pe, c_din, c_xp;
    logic [DW+1:0]  c_derr, c_xd;
    logic [PW-1:0]  c_period_nz;
    logic [TW-1:0]  c_isum_ext, c_clamped, c_round, c_pt, c_dt;

    function automatic logic [MAGW-1:0] mag_of(input logic [MAGW-1:0] x);
        mag_of = x[MAGW-1] ? (MAGW'(0) - x) : x;
    endfunction

    // cap the magnitude at 2^60, then apply the sign
    function automatic logic [TW-1:0] signed_term(input logic [WW-1:0] v, input logic neg);
        logic [WW-1:0] cap;
        logic [WW-1:0] m;
        logic [TW-1:0] mt;
        cap = WW'(1) << pcs_pkg::CAP_BITS;
        m   = (v > cap) ? cap : v;
        mt  = TW'(m);
        signed_term = neg ? (TW'(0) - mt) : mt;
    endfunction

    // upper limit first, then lower: crossed limits give the lower one
    function automatic logic [TW-1:0] clamp_term(input logic signed [TW-1:0] v,
                                                 input logic [DW-1:0] lo,
                                                 input logic [DW-1:0] hi);
        logic signed [TW-1:0] lo_s;
        logic signed [TW-1:0] hi_s;
        logic signed [TW-1:0] t;
        lo_s = {{(TW-DW){lo[DW-1]}}, lo} << SUM_FRAC_BITS;
        hi_s = {{(TW-DW){hi[DW-1]}}, hi} << SUM_FRAC_BITS;
        t = v;
        if (t > hi_s) begin
            t = hi_s;
        end
        if (t < lo_s) begin
            t = lo_s;
        end
        clamp_term = t;
    endfunction

    pcs_serial_unit #(
        .WW   (WW),
        .DIVN (LW_D)
    ) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (su_ctrl),
        .i_a      (su_a),
        .i_b      (su_b),
        .o_stat   (su_stat),
        .o_result (su_res)
    );

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.control_output = r_out_data;

    assign c_accept = i_item.valid && i_item.ready;
    assign c_p_meas = r_term_mode[pcs_pkg::MODE_P_MEAS_BIT];
    assign c_d_meas = r_term_mode[pcs_pkg::MODE_D_MEAS_BIT];

    always_comb begin
        // first compute seeds the previous values, so the derivative starts at zero
        c_err  = {i_item.target[DW-1], i_item.target}
               - {i_item.measured[DW-1], i_item.measured};
        c_pm   = r_started ? r_prev_meas : i_item.measured;
        c_pe   = r_started ? r_prev_err : c_err;
        c_din  = {i_item.measured[DW-1], i_item.measured} - {c_pm[DW-1], c_pm};
        c_derr = {c_err[DW], c_err} - {c_pe[DW], c_pe};
        c_xp   = c_p_meas ? c_din : c_err;
        c_xd   = c_d_meas ? {c_din[DW], c_din} : c_derr;

        c_app_cl = i_item.applied_output;
        if ($signed(c_app_cl) > $signed(r_limit_high)) begin
            c_app_cl = r_limit_high;
        end
        if ($signed(c_app_cl) < $signed(r_limit_low)) begin
            c_app_cl = r_limit_low;
        end

        c_period_nz = (r_period == '0) ? PW'(1) : r_period;
        c_isum_ext  = {{(TW-ISW){r_isum[ISW-1]}}, r_isum};
        c_clamped   = clamp_term(r_sum, r_limit_low, r_limit_high);
        c_round     = r_sum + (TW'(1) << (SUM_FRAC_BITS - 1));
        c_pt        = signed_term((su_res << PSL) >> PSR, r_xp[DW] ^ r_reverse);
        c_dt        = signed_term(su_res, r_xd[DW+1] ^ r_reverse);
    end

    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_prev_meas = r_prev_meas;
        n_prev_err  = r_prev_err;
        n_isum      = r_isum;
        n_err       = r_err;
        n_xp        = r_xp;
        n_xd        = r_xd;
        n_sum       = r_sum;
        n_pt        = r_pt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        su_ctrl     = '0;
        su_a        = '0;
        su_b        = '0;

        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_prev_meas = i_item.measured;
                    n_prev_err  = c_err;
                    if (i_item.operation == pcs_pkg::OP_OBSERVE) begin
                        n_isum = {c_app_cl, {SUM_FRAC_BITS{1'b0}}};
                    end else begin
                        n_started     = 1'b1;
                        n_err         = c_err;
                        n_xp          = c_xp;
                        n_xd          = c_xd;
                        su_ctrl.start = 1'b1;
                        su_a          = WW'(mag_of({c_err[DW], c_err}));
                        su_b          = r_integ_gain;
                        n_state       = S_I_MUL1;
                    end
                end
            end
            S_I_MUL1: begin
                if (su_stat.done) begin
                    su_ctrl.start = 1'b1;
                    su_a          = su_res;
                    su_b          = GW'(c_period_nz);
                    n_state       = S_I_MUL2;
                end
            end
            S_I_MUL2: begin
                if (su_stat.done) begin
                    n_state = S_I_ADD;
                end
            end
            S_I_ADD: begin
                n_sum         = c_isum_ext + signed_term(su_res >> IS, r_err[DW] ^ r_reverse);
                su_ctrl.start = 1'b1;
                su_a          = WW'(mag_of({r_xp[DW], r_xp}));
                su_b          = r_prop_gain;
                n_state       = S_P_MUL;
            end
            S_P_MUL: begin
                if (su_stat.done) begin
                    n_state = S_P_ADD;
                end
            end
            S_P_ADD: begin
                // P on measurement folds into the integral sum before its clamp
                if (c_p_meas) begin
                    n_sum = r_sum - c_pt;
                    n_pt  = '0;
                end else begin
                    n_pt  = c_pt;
                end
                su_ctrl.start = 1'b1;
                su_a          = WW'(mag_of(r_xd));
                su_b          = r_deriv_gain;
                n_state       = S_I_CLAMP;
            end
            S_I_CLAMP: begin
                n_isum  = c_clamped[ISW-1:0];
                n_state = S_RES_P;
            end
            S_RES_P: begin
                n_sum   = c_isum_ext + r_pt;
                n_state = S_D_MUL;
            end
            S_D_MUL: begin
                if (su_stat.done) begin
                    su_ctrl.start  = 1'b1;
                    su_ctrl.divide = 1'b1;
                    su_a           = su_res << DS;
                    su_b           = GW'(c_period_nz);
                    n_state        = S_D_DIV;
                end
            end
            S_D_DIV: begin
                if (su_stat.done) begin
                    n_state = S_D_ADD;
                end
            end
            S_D_ADD: begin
                n_sum   = c_d_meas ? (r_sum - c_dt) : (r_sum + c_dt);
                n_state = S_O_CLAMP;
            end
            S_O_CLAMP: begin
                n_sum   = c_clamped;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // round half up: add one half, keep the integer bits
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = c_round[SUM_FRAC_BITS +: DW];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_prev_meas <= '0;
            r_prev_err  <= '0;
            r_isum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_prev_meas <= n_prev_meas;
            r_prev_err  <= n_prev_err;
            r_isum      <= n_isum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err      <= n_err;
        r_xp       <= n_xp;
        r_xd       <= n_xd;
        r_sum      <= n_sum;
        r_pt       <= n_pt;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_period     <= pcs_pkg::PERIOD_RESET;
            r_limit_low  <= {1'b1, {(DW-1){1'b0}}};
            r_limit_high <= {1'b0, {(DW-1){1'b1}}};
            r_reverse    <= 1'b0;
            r_term_mode  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcs_pkg::REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GW-1:0];
                pcs_pkg::REG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GW-1:0];
                pcs_pkg::REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GW-1:0];
                pcs_pkg::REG_PERIOD:     r_period     <= i_cfg_data[PW-1:0];
                pcs_pkg::REG_LIMIT_LOW:  r_limit_low  <= i_cfg_data[DW-1:0];
                pcs_pkg::REG_LIMIT_HIGH: r_limit_high <= i_cfg_data[DW-1:0];
                pcs_pkg::REG_REVERSE:    r_reverse    <= i_cfg_data[0];
                pcs_pkg::REG_TERM_MODE:  r_term_mode  <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        su_stat.done |-> (r_state == S_I_MUL1 || r_state == S_I_MUL2 || r_state == S_P_MUL
                          || r_state == S_D_MUL || r_state == S_D_DIV))
        else $error("serial unit finished outside a wait state");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        su_stat.busy |-> !i_item.ready)
        else $error("item taken while serial unit busy");

    a_result_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == S_ROUND))
        else $error("result raised outside rounding step");

    a_compute_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_accept && i_item.operation == pcs_pkg::OP_COMPUTE)
            |=> (r_started && r_state == S_I_MUL1))
        else $error("compute item did not start the integral multiply");
`endif

endmodule
